[sv/lme_pkg.sv]
// shared constants and types of the log-mel frame extractor
`default_nettype none
package lme_pkg;

  localparam int unsigned FFT_SIZE_DEF    = 512;
  localparam int unsigned MAX_BANDS_DEF   = 64;
  localparam int unsigned COEFF_DEPTH_DEF = 2048;

  localparam logic [9:0]  HOP_RESET   = 10'd160;
  localparam logic [9:0]  FRAME_RESET = 10'd400;
  localparam logic [6:0]  BANDS_RESET = 7'd40;
  localparam logic [31:0] FLOOR_RESET = 32'd1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] LN2_Q32     = 64'd2977044472;

  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 66;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WINDOW = 2'd1,
    CMD_COEFF  = 2'd2,
    CMD_LIMITS = 2'd3
  } cmd_e;

  localparam logic [1:0] CFG_HOP    = 2'd0;
  localparam logic [1:0] CFG_FRAME  = 2'd1;
  localparam logic [1:0] CFG_BANDS  = 2'd2;
  localparam logic [1:0] CFG_FLOOR  = 2'd3;

endpackage
`default_nettype wire

[sv/lme_mult.sv]
// shared registered signed multiplier
`default_nettype none
module lme_mult (
  input  wire logic                                   clk_i,
  input  wire logic signed [lme_pkg::MUL_W-1:0]      a_i,
  input  wire logic signed [lme_pkg::MUL_W-1:0]      b_i,
  output logic signed      [lme_pkg::PROD_W-1:0]     p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule
`default_nettype wire

[sv/lme_twiddle.sv]
// twiddle table, cos and -sin in q2.30, with registered read
`default_nettype none
module lme_twiddle #(
  parameter int unsigned FFT_SIZE = lme_pkg::FFT_SIZE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic [$clog2(FFT_SIZE)-2:0]     addr_i,
  output logic signed [31:0]                   re_o,
  output logic signed [31:0]                   im_o
);

  localparam int unsigned QUARTER = FFT_SIZE / 4;
  localparam int unsigned Q_HALF  = QUARTER / 2;
  localparam int unsigned EIGHTH  = FFT_SIZE / 8;
  localparam int unsigned HALF    = FFT_SIZE / 2;

  function automatic logic [63:0] octant(input logic [63:0] k);
    logic [63:0] x, x2, ts, tc;
    logic signed [63:0] ss, cs;
    x  = (lme_pkg::HALF_PI_Q30 * k + 64'(Q_HALF)) / QUARTER;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = $signed(x);
    cs = $signed(tc);
    ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;
    ss = ss - $signed(ts);        cs = cs - $signed(tc);
    ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;
    ss = ss + $signed(ts);        cs = cs + $signed(tc);
    ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;
    ss = ss - $signed(ts);        cs = cs - $signed(tc);
    ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;
    ss = ss + $signed(ts);        cs = cs + $signed(tc);
    ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;
    ss = ss - $signed(ts);        cs = cs - $signed(tc);
    ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132;
    ss = ss + $signed(ts);        cs = cs + $signed(tc);
    ts = ((ts * x2) >> 30) / 210; tc = ((tc * x2) >> 30) / 182;
    ss = ss - $signed(ts);        cs = cs - $signed(tc);
    return {ss[31:0], cs[31:0]};
  endfunction

  function automatic logic [HALF*64-1:0] build_table();
    logic [HALF*64-1:0] tab;
    logic [63:0] o;
    logic signed [31:0] c, s, t;
    int unsigned kk;
    tab = '0;
    for (int unsigned k = 0; k < HALF; k++) begin
      kk = (k < QUARTER) ? k : k - QUARTER;
      if (kk <= EIGHTH) begin
        o = octant(64'(kk));
        c = o[31:0];
        s = o[63:32];
      end else begin
        o = octant(64'(QUARTER - kk));
        s = o[31:0];
        c = o[63:32];
      end
      if (k >= QUARTER) begin
        t = c;
        c = -s;
        s = t;
      end
      tab[k*64 +: 64] = {-s, c};
    end
    return tab;
  endfunction

  localparam logic [HALF*64-1:0] TW_TAB = build_table();

  always_ff @(posedge clk_i) begin
    re_o <= TW_TAB[32'(addr_i)*64 +: 32];
    im_o <= TW_TAB[32'(addr_i)*64 + 32 +: 32];
  end

endmodule
`default_nettype wire

[sv/log_mel_frame_extractor.sv]
// log-mel frame extractor top level: stores, sequencer and datapath
// usage: command items come in on the s_axis channel, kind in tuser, fields in tdata.
// sample requests fill a ring; load requests write the window, band coefficient and
// band limit stores. once frame_length samples have arrived, and after every hop_length
// samples after that, the sample request that completes the count starts a frame, and
// s_axis_tready stays low until the frame is done. a frame runs windowing, then the
// butterflies, then per band the bin sums, normalization, log squarings and scaling.
// the frame time is set by the single shared multiplier, which every product goes
// through, and by the fft store, which has one read port and one write port.
// results leave on m_axis, one per band, log energy and band index in tdata, tlast on
// the last band. a result sits in the output register until taken; when the receiver
// stalls, the sequencer waits before the next band is loaded into it.
// after reset the sample ring is swept to zero, tready low meanwhile;
// configuration writes through cfg_we_i are taken at any time, but only while idle
// do they give defined frames.
`default_nettype none
module log_mel_frame_extractor #(
  parameter int unsigned FFT_SIZE    = lme_pkg::FFT_SIZE_DEF,
  parameter int unsigned MAX_BANDS   = lme_pkg::MAX_BANDS_DEF,
  parameter int unsigned COEFF_DEPTH = lme_pkg::COEFF_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // position, sample, coefficient, band_low, band_high, zero pad
  input  wire logic [63:0] s_axis_tdata,
  // command
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // band, log_energy, zero pad
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned FA_W      = $clog2(FFT_SIZE);
  localparam int unsigned TW_W      = FA_W - 1;
  localparam int unsigned SW        = $clog2(FA_W);
  localparam int unsigned FL_W      = FA_W + 1;
  localparam int unsigned BA_W      = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int unsigned CI_W      = $clog2(COEFF_DEPTH);
  localparam int unsigned HALF_BINS = FFT_SIZE / 2 + 1;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_BFLY  = 4'd3;
  localparam logic [3:0] ST_BAND  = 4'd4;
  localparam logic [3:0] ST_BIN   = 4'd5;
  localparam logic [3:0] ST_NORM  = 4'd6;
  localparam logic [3:0] ST_SQR   = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic signed [65:0] RND = 66'sd1073741824;

  function automatic logic [FA_W-1:0] bitrev(input logic [FA_W-1:0] v);
    logic [FA_W-1:0] r;
    for (int b = 0; b < FA_W; b++) begin
      r[FA_W-1-b] = v[b];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_shift(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v >>> 31;
    if (s > 66'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (s < -66'sd2147483648) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  // input fields
  lme_pkg::cmd_e cmd;
  logic [10:0]   in_pos;
  logic [15:0]   in_sample;
  logic [15:0]   in_coef;
  logic [8:0]    in_blo;
  logic [8:0]    in_bhi;
  logic          in_acc;

  assign cmd       = lme_pkg::cmd_e'(s_axis_tuser);
  assign in_pos    = s_axis_tdata[10:0];
  assign in_sample = s_axis_tdata[26:11];
  assign in_coef   = s_axis_tdata[42:27];
  assign in_blo    = s_axis_tdata[51:43];
  assign in_bhi    = s_axis_tdata[60:52];

  // configuration
  logic [9:0]  hop_q, flen_q;
  logic [6:0]  nbands_q;
  logic [31:0] floor_q;

  int unsigned fl_int, hop_int, nb_int;
  logic [FL_W-1:0] fl_eff;
  logic [5:0]      nb_last;
  logic [63:0]     floor64;

  always_comb begin
    fl_int  = (flen_q == 10'd0) ? 1 :
              ((32'(flen_q) > FFT_SIZE) ? FFT_SIZE : 32'(flen_q));
    hop_int = (hop_q == 10'd0) ? 1 : 32'(hop_q);
    nb_int  = (nbands_q == 7'd0) ? 1 :
              ((32'(nbands_q) > MAX_BANDS) ? MAX_BANDS : 32'(nbands_q));
    fl_eff  = FL_W'(fl_int);
    nb_last = 6'(nb_int - 1);
    floor64 = (floor_q == 32'd0) ? 64'd1 : {32'd0, floor_q};
  end

  // control and datapath registers
  logic [3:0]       state_q, state_d;
  logic [3:0]       step_q, step_d;
  logic [FA_W-1:0]  idx_q, idx_d;
  logic [FA_W-1:0]  ridx_q, ridx_d;
  logic [FA_W-1:0]  wp_q, wp_d;
  logic [9:0]       cnt_q, cnt_d;
  logic             first_q, first_d;
  logic [TW_W-1:0]  bcnt_q, bcnt_d;
  logic [SW-1:0]    stage_q, stage_d;
  logic [5:0]       m_q, m_d;
  logic [8:0]       k_q, k_d;
  logic [15:0]      off_q, off_d;
  logic [4:0]       sqn_q, sqn_d;
  logic             out_valid_q, out_valid_d;

  logic signed [31:0] ar_q, ar_d, ai_q, ai_d, br_q, br_d, bi_q, bi_d, im_q, im_d;
  logic signed [63:0] tr_q, tr_d, ti_q, ti_d;
  logic [15:0]        coef_q, coef_d;
  logic [63:0]        pw_q, pw_d, th_q, th_d, en_q, en_d;
  logic [5:0]         e_q, e_d;
  logic [31:0]        mq_q, mq_d;
  logic [23:0]        frac_q, frac_d;
  logic [21:0]        res_q, res_d;
  logic [8:0]         lo_q, lo_d, hi_q, hi_d;
  logic [5:0]         out_band_q;
  logic [21:0]        out_log_q;
  logic               out_last_q;
  logic               out_load;

  // stores
  logic [15:0] ring_mem [FFT_SIZE];
  logic [15:0] win_mem  [FFT_SIZE];
  logic [15:0] filt_mem [COEFF_DEPTH];
  logic [8:0]  lo_mem   [MAX_BANDS];
  logic [8:0]  hi_mem   [MAX_BANDS];
  logic [63:0] fft_mem  [FFT_SIZE];

  logic [15:0] ring_rd, win_rd, filt_rd;
  logic [8:0]  lo_rd, hi_rd;
  logic [63:0] fft_rd;

  logic            ring_we;
  logic [FA_W-1:0] ring_waddr;
  logic [15:0]     ring_wdata;
  logic            win_we, filt_we, lim_we;
  logic            fft_we;
  logic [FA_W-1:0] fft_waddr, fft_raddr;
  logic [63:0]     fft_wdata;
  logic [15:0]     ci;
  logic            ci_ok;

  // shared multiplier and twiddle table
  logic signed [lme_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [lme_pkg::PROD_W-1:0] prod;
  logic signed [31:0]                tw_re, tw_im;
  logic [FA_W-1:0]                   bf_j, bf_a, bf_b;
  logic [TW_W-1:0]                   tw_addr;

  lme_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  lme_twiddle #(.FFT_SIZE(FFT_SIZE)) u_twiddle (
    .clk_i  (clk_i),
    .addr_i (tw_addr),
    .re_o   (tw_re),
    .im_o   (tw_im)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ring_we    = (state_q == ST_CLEAR) || (in_acc && cmd == lme_pkg::CMD_SAMPLE);
  assign ring_waddr = (state_q == ST_CLEAR) ? idx_q : wp_q;
  assign ring_wdata = (state_q == ST_CLEAR) ? 16'd0 : in_sample;
  assign win_we     = in_acc && cmd == lme_pkg::CMD_WINDOW && 32'(in_pos) < FFT_SIZE;
  assign filt_we    = in_acc && cmd == lme_pkg::CMD_COEFF && 32'(in_pos) < COEFF_DEPTH;
  assign lim_we     = in_acc && cmd == lme_pkg::CMD_LIMITS && 32'(in_pos) < MAX_BANDS;

  assign ci    = off_q + 16'(k_q) - 16'(lo_q);
  assign ci_ok = 32'(ci) < COEFF_DEPTH;

  // butterfly addressing
  always_comb begin
    bf_j    = {1'b0, bcnt_q} & ((FA_W'(1) << stage_q) - FA_W'(1));
    bf_a    = (({1'b0, bcnt_q} >> stage_q) << (32'(stage_q) + 32'd1)) | bf_j;
    bf_b    = bf_a | (FA_W'(1) << stage_q);
    tw_addr = TW_W'(bf_j << (32'(FA_W - 1) - 32'(stage_q)));
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_rd <= ring_mem[ridx_q];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[in_pos[FA_W-1:0]] <= in_coef;
    end
    win_rd <= win_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (filt_we) begin
      filt_mem[CI_W'(32'(in_pos))] <= in_coef;
    end
    filt_rd <= filt_mem[CI_W'(32'(ci))];
  end

  always_ff @(posedge clk_i) begin
    if (lim_we) begin
      lo_mem[in_pos[BA_W-1:0]] <= in_blo;
      hi_mem[in_pos[BA_W-1:0]] <= in_bhi;
    end
    lo_rd <= lo_mem[m_q[BA_W-1:0]];
    hi_rd <= hi_mem[m_q[BA_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (fft_we) begin
      fft_mem[fft_waddr] <= fft_wdata;
    end
    fft_rd <= fft_mem[fft_raddr];
  end

  // butterfly sums
  logic signed [65:0] ar_w, ai_w, tr_w, ti_w;
  assign ar_w = $signed({{34{ar_q[31]}}, ar_q}) <<< 30;
  assign ai_w = $signed({{34{ai_q[31]}}, ai_q}) <<< 30;
  assign tr_w = $signed({{2{tr_q[63]}}, tr_q});
  assign ti_w = $signed({{2{ti_q[63]}}, ti_q});

  logic [9:0]  cnt_new;
  logic [64:0] esum;
  logic [63:0] term;
  logic [63:0] scaled;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    idx_d       = idx_q;
    ridx_d      = ridx_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    bcnt_d      = bcnt_q;
    stage_d     = stage_q;
    m_d         = m_q;
    k_d         = k_q;
    off_d       = off_q;
    sqn_d       = sqn_q;
    out_valid_d = out_valid_q;
    ar_d        = ar_q;
    ai_d        = ai_q;
    br_d        = br_q;
    bi_d        = bi_q;
    im_d        = im_q;
    tr_d        = tr_q;
    ti_d        = ti_q;
    coef_d      = coef_q;
    pw_d        = pw_q;
    th_d        = th_q;
    en_d        = en_q;
    e_d         = e_q;
    mq_d        = mq_q;
    frac_d      = frac_q;
    res_d       = res_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_load    = 1'b0;
    fft_we      = 1'b0;
    fft_waddr   = '0;
    fft_wdata   = '0;
    fft_raddr   = '0;
    mul_a       = '0;
    mul_b       = '0;
    cnt_new     = (cnt_q != 10'd1023) ? cnt_q + 10'd1 : cnt_q;
    term        = th_q + 64'(prod[47:16]);
    esum        = {1'b0, en_q} + {1'b0, term};
    scaled      = prod[63:0] + (64'd1 << 39);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        idx_d = idx_q + FA_W'(1);
        if (idx_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && cmd == lme_pkg::CMD_SAMPLE) begin
          wp_d = wp_q + FA_W'(1);
          if (32'(cnt_new) >= (first_q ? hop_int : fl_int)) begin
            cnt_d   = 10'd0;
            first_d = 1'b1;
            state_d = ST_LOAD;
            step_d  = 4'd0;
            idx_d   = '0;
            ridx_d  = wp_q + FA_W'(1) - fl_eff[FA_W-1:0];
          end else begin
            cnt_d = cnt_new;
          end
        end
      end
      ST_LOAD: begin
        unique case (step_q)
          4'd0: step_d = 4'd1;
          4'd1: begin
            mul_a  = {{17{ring_rd[15]}}, ring_rd};
            mul_b  = {17'd0, win_rd};
            step_d = 4'd2;
          end
          4'd2: begin
            fft_we    = 1'b1;
            fft_waddr = bitrev(idx_q);
            fft_wdata = (32'(idx_q) < 32'(fl_eff)) ? {32'd0, prod[31:0]} : 64'd0;
            idx_d     = idx_q + FA_W'(1);
            ridx_d    = ridx_q + FA_W'(1);
            step_d    = 4'd0;
            if (idx_q == '1) begin
              state_d = ST_BFLY;
              bcnt_d  = '0;
              stage_d = '0;
            end
          end
          default: step_d = 4'd0;
        endcase
      end
      ST_BFLY: begin
        fft_raddr = (step_q == 4'd0) ? bf_a : bf_b;
        unique case (step_q)
          4'd0: step_d = 4'd1;
          4'd1: begin
            ar_d   = fft_rd[31:0];
            ai_d   = fft_rd[63:32];
            step_d = 4'd2;
          end
          4'd2: begin
            br_d   = fft_rd[31:0];
            bi_d   = fft_rd[63:32];
            mul_a  = {fft_rd[31], fft_rd[31:0]};
            mul_b  = {tw_re[31], tw_re};
            step_d = 4'd3;
          end
          4'd3: begin
            mul_a  = {bi_q[31], bi_q};
            mul_b  = {tw_im[31], tw_im};
            tr_d   = prod[63:0];
            step_d = 4'd4;
          end
          4'd4: begin
            mul_a  = {br_q[31], br_q};
            mul_b  = {tw_im[31], tw_im};
            tr_d   = tr_q - prod[63:0];
            step_d = 4'd5;
          end
          4'd5: begin
            mul_a  = {bi_q[31], bi_q};
            mul_b  = {tw_re[31], tw_re};
            ti_d   = prod[63:0];
            step_d = 4'd6;
          end
          4'd6: begin
            ti_d   = ti_q + prod[63:0];
            step_d = 4'd7;
          end
          4'd7: begin
            fft_we    = 1'b1;
            fft_waddr = bf_a;
            fft_wdata = {sat_shift(ai_w + ti_w + RND), sat_shift(ar_w + tr_w + RND)};
            step_d    = 4'd8;
          end
          4'd8: begin
            fft_we    = 1'b1;
            fft_waddr = bf_b;
            fft_wdata = {sat_shift(ai_w - ti_w + RND), sat_shift(ar_w - tr_w + RND)};
            step_d    = 4'd0;
            bcnt_d    = bcnt_q + TW_W'(1);
            if (bcnt_q == '1) begin
              if (32'(stage_q) == FA_W - 1) begin
                state_d = ST_BAND;
                m_d     = 6'd0;
                off_d   = 16'd0;
              end else begin
                stage_d = stage_q + SW'(1);
              end
            end
          end
          default: step_d = 4'd0;
        endcase
      end
      ST_BAND: begin
        if (step_q == 4'd0) begin
          step_d = 4'd1;
        end else begin
          lo_d    = lo_rd;
          hi_d    = hi_rd;
          k_d     = lo_rd;
          en_d    = 64'd0;
          step_d  = 4'd0;
          state_d = ST_BIN;
        end
      end
      ST_BIN: begin
        fft_raddr = FA_W'(32'(k_q));
        unique case (step_q)
          4'd0: begin
            if (k_q < hi_q && 32'(k_q) < HALF_BINS) begin
              step_d = 4'd1;
            end else begin
              if (hi_q > lo_q) begin
                off_d = off_q + 16'(hi_q - lo_q);
              end
              en_d    = (en_q < floor64) ? floor64 : en_q;
              e_d     = 6'd63;
              state_d = ST_NORM;
            end
          end
          4'd1: begin
            mul_a  = {fft_rd[31], fft_rd[31:0]};
            mul_b  = {fft_rd[31], fft_rd[31:0]};
            im_d   = fft_rd[63:32];
            coef_d = ci_ok ? filt_rd : 16'd0;
            step_d = 4'd2;
          end
          4'd2: begin
            mul_a  = {im_q[31], im_q};
            mul_b  = {im_q[31], im_q};
            pw_d   = prod[63:0];
            step_d = 4'd3;
          end
          4'd3: begin
            pw_d   = pw_q + prod[63:0];
            step_d = 4'd4;
          end
          4'd4: begin
            mul_a  = {17'd0, coef_q};
            mul_b  = {1'b0, pw_q[63:32]};
            step_d = 4'd5;
          end
          4'd5: begin
            mul_a  = {17'd0, coef_q};
            mul_b  = {1'b0, pw_q[31:0]};
            th_d   = {prod[47:0], 16'd0};
            step_d = 4'd6;
          end
          4'd6: begin
            en_d   = esum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : esum[63:0];
            k_d    = k_q + 9'd1;
            step_d = 4'd0;
          end
          default: step_d = 4'd0;
        endcase
      end
      ST_NORM: begin
        if (!en_q[63] && e_q != 6'd0) begin
          en_d = en_q << 1;
          e_d  = e_q - 6'd1;
        end else begin
          mq_d    = en_q[63:32];
          frac_d  = 24'd0;
          sqn_d   = 5'd0;
          step_d  = 4'd0;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (step_q == 4'd0) begin
          mul_a  = {1'b0, mq_q};
          mul_b  = {1'b0, mq_q};
          step_d = 4'd1;
        end else begin
          if (prod[63]) begin
            frac_d[5'd23 - sqn_q] = 1'b1;
            mq_d = prod[63:32];
          end else begin
            mq_d = prod[62:31];
          end
          sqn_d  = sqn_q + 5'd1;
          step_d = 4'd0;
          if (sqn_q == 5'd23) begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (step_q == 4'd0) begin
          mul_a  = {3'd0, e_q, frac_q};
          mul_b  = {1'b0, lme_pkg::LN2_Q32[31:0]};
          step_d = 4'd1;
        end else begin
          res_d   = scaled[61:40];
          step_d  = 4'd0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (m_q == nb_last) begin
            state_d = ST_IDLE;
          end else begin
            m_d     = m_q + 6'd1;
            step_d  = 4'd0;
            state_d = ST_BAND;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= 4'd0;
      idx_q       <= '0;
      ridx_q      <= '0;
      wp_q        <= '0;
      cnt_q       <= 10'd0;
      first_q     <= 1'b0;
      bcnt_q      <= '0;
      stage_q     <= '0;
      m_q         <= 6'd0;
      k_q         <= 9'd0;
      off_q       <= 16'd0;
      sqn_q       <= 5'd0;
      out_valid_q <= 1'b0;
      hop_q       <= lme_pkg::HOP_RESET;
      flen_q      <= lme_pkg::FRAME_RESET;
      nbands_q    <= lme_pkg::BANDS_RESET;
      floor_q     <= lme_pkg::FLOOR_RESET;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      ridx_q      <= ridx_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      bcnt_q      <= bcnt_d;
      stage_q     <= stage_d;
      m_q         <= m_d;
      k_q         <= k_d;
      off_q       <= off_d;
      sqn_q       <= sqn_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lme_pkg::CFG_HOP:   hop_q    <= cfg_data_i[9:0];
          lme_pkg::CFG_FRAME: flen_q   <= cfg_data_i[9:0];
          lme_pkg::CFG_BANDS: nbands_q <= cfg_data_i[6:0];
          lme_pkg::CFG_FLOOR: floor_q  <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ar_q   <= ar_d;
    ai_q   <= ai_d;
    br_q   <= br_d;
    bi_q   <= bi_d;
    im_q   <= im_d;
    tr_q   <= tr_d;
    ti_q   <= ti_d;
    coef_q <= coef_d;
    pw_q   <= pw_d;
    th_q   <= th_d;
    en_q   <= en_d;
    e_q    <= e_d;
    mq_q   <= mq_d;
    frac_q <= frac_d;
    res_q  <= res_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    if (out_load) begin
      out_band_q <= m_q;
      out_log_q  <= res_q;
      out_last_q <= (m_q == nb_last);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_log_q, out_band_q};
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
